// ----- rtl/core/jac_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the joystick axis conditioner.
package jac_pkg;

   localparam int CENTER_W     = 12;
   localparam int SCALE_LOW_W  = 11;
   localparam int SCALE_HIGH_W = 10;
   localparam int DEAD_ZONE_W  = 10;
   localparam int POS_W        = 11;
   localparam int FAC_W        = 11;
   localparam int QUO_W        = 11;
   localparam int CNT_W        = 4;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_SEL_W    = 3;

   localparam logic [POS_W-1:0] POS_POS_MAX = 11'd1023;
   localparam logic [POS_W-1:0] POS_NEG_MAG = 11'd1024;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_SCALE_LOW  = 3'd0,
      REG_SCALE_HIGH = 3'd1,
      REG_DEAD_ZONE  = 3'd2,
      REG_CENTER_H   = 3'd3,
      REG_CENTER_V   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [SCALE_LOW_W-1:0] scale_low;
      logic [SCALE_HIGH_W-1:0]       scale_high;
      logic [DEAD_ZONE_W-1:0]        dead_zone;
      logic [CENTER_W-1:0]           center_h;
      logic [CENTER_W-1:0]           center_v;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

// ----- rtl/core/jac_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample and result beats.
interface jac_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic                   axis;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, axis, sample, input ready);
   modport sink (input valid, axis, sample, output ready);
endinterface

interface jac_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] position;
   logic        in_dead_zone;

   modport source (output valid, position, in_dead_zone, input ready);
   modport sink (input valid, position, in_dead_zone, output ready);
endinterface

// ----- rtl/core/jac_csr.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers.
module jac_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [jac_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [jac_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [jac_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output jac_pkg::cfg_type                cfg
);
   import jac_pkg::*;

   localparam cfg_type CFG_RESET = '{
      scale_low:  -11'sd100,
      scale_high: 10'd100,
      dead_zone:  10'd10,
      center_h:   12'd2048,
      center_v:   12'd2048
   };

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type sel;
   logic          wr_en;

   assign sel    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (sel)
         REG_SCALE_LOW: begin
            prdata = {{(CSR_DATA_W-SCALE_LOW_W){cfg_ff.scale_low[SCALE_LOW_W-1]}},
                      cfg_ff.scale_low};
            if (wr_en) begin
               cfg_in.scale_low = pwdata[SCALE_LOW_W-1:0];
            end
         end
         REG_SCALE_HIGH: begin
            prdata = CSR_DATA_W'(cfg_ff.scale_high);
            if (wr_en) begin
               cfg_in.scale_high = pwdata[SCALE_HIGH_W-1:0];
            end
         end
         REG_DEAD_ZONE: begin
            prdata = CSR_DATA_W'(cfg_ff.dead_zone);
            if (wr_en) begin
               cfg_in.dead_zone = pwdata[DEAD_ZONE_W-1:0];
            end
         end
         REG_CENTER_H: begin
            prdata = CSR_DATA_W'(cfg_ff.center_h);
            if (wr_en) begin
               cfg_in.center_h = pwdata[CENTER_W-1:0];
            end
         end
         REG_CENTER_V: begin
            prdata = CSR_DATA_W'(cfg_ff.center_v);
            if (wr_en) begin
               cfg_in.center_v = pwdata[CENTER_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/jac_track.sv -----
`timescale 1ns / 1ps
// Per-axis sample windows with running sums and peak sums.
module jac_track #(
   parameter int WINDOW_DEPTH = 5,
   parameter int SAMPLE_BITS  = 12,
   parameter int SUM_W        = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   axis,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   rd_axis,
   output logic [SUM_W-1:0]       sum,
   output logic [SUM_W-1:0]       peak
);

   localparam int FULL_SUM   = WINDOW_DEPTH * ((2 ** SAMPLE_BITS) - 1);
   localparam int PEAK_RESET = (FULL_SUM * 9 + 5) / 10;

   logic [SAMPLE_BITS-1:0] win_ff [2][WINDOW_DEPTH];
   logic [SUM_W-1:0]       sum_ff [2];
   logic [SUM_W-1:0]       peak_ff [2];
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_in;
   logic [SUM_W-1:0]       peak_in;

   // oldest sample leaves, new one enters
   always_comb begin
      sum_wide = {1'b0, sum_ff[axis]} + (SUM_W+1)'(sample) - (SUM_W+1)'(win_ff[axis][0]);
      sum_in   = sum_wide[SUM_W-1:0];
      peak_in  = (sum_in > peak_ff[axis]) ? sum_in : peak_ff[axis];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               win_ff[a][i] <= '0;
            end
            sum_ff[a]  <= '0;
            peak_ff[a] <= SUM_W'(PEAK_RESET);
         end
      end else if (push) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            win_ff[axis][i] <= win_ff[axis][i+1];
         end
         win_ff[axis][WINDOW_DEPTH-1] <= sample;
         sum_ff[axis]                 <= sum_in;
         peak_ff[axis]                <= peak_in;
      end
   end

   assign sum  = sum_ff[rd_axis];
   assign peak = peak_ff[rd_axis];

endmodule

// ----- rtl/core/jac_divide.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per step; top quotient bit flags overflow.
module jac_divide #(
   parameter int PROD_W = 31,
   parameter int DEN_W  = 20
) (
   input  logic                        clock,
   input  jac_pkg::div_ctl_type        ctl,
   input  logic [PROD_W-1:0]           dividend,
   input  logic [DEN_W-1:0]            divisor,
   output logic [jac_pkg::QUO_W-1:0]   quotient
);
   import jac_pkg::*;

   logic [PROD_W-1:0] rem_ff;
   logic [PROD_W-1:0] rem_in;
   logic [PROD_W-1:0] den_ff;
   logic [PROD_W-1:0] den_in;
   logic [QUO_W-1:0]  quo_ff;
   logic [QUO_W-1:0]  quo_in;
   logic [PROD_W:0]   diff;
   logic              take;

   assign diff = {1'b0, rem_ff} - {1'b0, den_ff};
   assign take = ~diff[PROD_W];

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = dividend;
         den_in = PROD_W'(divisor) << (QUO_W - 1);
         quo_in = '0;
      end else if (ctl.step) begin
         if (take) begin
            rem_in = diff[PROD_W-1:0];
         end
         den_in = den_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// ----- rtl/core/joystick_axis_conditioner_core.sv -----
`timescale 1ns / 1ps
// Top level of the joystick axis conditioner.
//
// req_bus carries one converter sample per beat, tagged with its axis
// (0 horizontal, 1 vertical). Each sample enters that axis's window; the
// window sum is scaled around the configured center to the user range and
// passed through the dead zone. rsp_bus returns one result beat per sample.
// csr_* is an APB-style register port (scale_low, scale_high, dead_zone,
// center_horizontal, center_vertical at 4-byte steps), written while idle.
//
// Per sample: a setup state, a multiply state that loads the divider, eleven
// divider steps and a final state that loads the result register; the
// sequencer then returns to idle, where it takes the next beat, so a new
// sample is taken only once the last one's result is loaded.
// req_bus.ready is high only while no sample is in work; a pending result
// does not block the next sample, but that sample waits at its last step
// until rsp_bus takes the held beat.
// Reset (synchronous) empties the windows, returns peaks and registers to
// their defaults and drops any pending result.
module joystick_axis_conditioner_core #(
   parameter int WINDOW_DEPTH = 5,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   jac_req_if.sink                         req_bus,
   jac_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [jac_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [jac_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [jac_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import jac_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int CEN_W  = CENTER_W + $clog2(WINDOW_DEPTH);
   localparam int CMP_W  = (SUM_W > CEN_W) ? SUM_W : CEN_W;
   localparam int PROD_W = CMP_W + FAC_W;

   cfg_type           cfg;
   state_type         state_ff;
   state_type         state_in;
   div_ctl_type       div_ctl;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              axis_ff;
   logic              accept;
   logic              rsp_load;

   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  peak;
   logic [CMP_W-1:0]  sum_x;
   logic [CMP_W-1:0]  peak_x;
   logic [CMP_W-1:0]  c_val;
   logic [CENTER_W-1:0] center_sel;
   logic [SCALE_LOW_W:0] f_wide;
   logic [SCALE_LOW_W:0] f_negated;
   logic              f_neg;
   logic [FAC_W-1:0]  f_mag;

   logic [CMP_W-1:0]  dev_ff;
   logic [CMP_W-1:0]  dev_in;
   logic [CMP_W-1:0]  range_ff;
   logic [CMP_W-1:0]  range_in;
   logic [FAC_W-1:0]  fac_ff;
   logic [FAC_W-1:0]  fac_in;
   logic              neg_ff;
   logic              neg_in;
   logic              zero_ff;
   logic              zero_in;

   logic [PROD_W-1:0] product;
   logic [QUO_W-1:0]  quotient;
   logic [POS_W-1:0]  mag;
   logic              forced;
   logic [POS_W-1:0]  pos_in;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              dz_ff;

   jac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   jac_track #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .SUM_W        (SUM_W)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .axis    (req_bus.axis),
      .sample  (req_bus.sample),
      .rd_axis (axis_ff),
      .sum     (sum),
      .peak    (peak)
   );

   assign product = PROD_W'(dev_ff) * PROD_W'(fac_ff);

   jac_divide #(
      .PROD_W (PROD_W),
      .DEN_W  (CMP_W)
   ) u_divide (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (product),
      .divisor  (range_ff),
      .quotient (quotient)
   );

   assign accept = req_bus.valid & req_bus.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      div_ctl.load  = 1'b0;
      div_ctl.step  = 1'b0;
      req_bus.ready = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            div_ctl.load = 1'b1;
            cnt_in       = CNT_W'(QUO_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            div_ctl.step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (accept) begin
         axis_ff <= req_bus.axis;
      end
   end

   // deviation, range and factor for the selected side of center
   always_comb begin
      center_sel = axis_ff ? cfg.center_v : cfg.center_h;
      c_val      = CMP_W'(center_sel) * CMP_W'(WINDOW_DEPTH);
      sum_x      = CMP_W'(sum);
      peak_x     = CMP_W'(peak);
      f_wide     = {cfg.scale_low[SCALE_LOW_W-1], cfg.scale_low} - 12'd1;
      f_negated  = -f_wide;
      f_neg      = f_wide[SCALE_LOW_W];
      f_mag      = f_neg ? f_negated[FAC_W-1:0] : f_wide[FAC_W-1:0];
      if (sum_x >= c_val) begin
         dev_in   = sum_x - c_val;
         range_in = (peak_x >= c_val) ? (peak_x - c_val) : '0;
         fac_in   = FAC_W'(cfg.scale_high) + 1'b1;
         neg_in   = 1'b0;
      end else begin
         // trough sum never leaves zero, so the low range is the center sum
         dev_in   = c_val - sum_x;
         range_in = c_val;
         fac_in   = f_mag;
         neg_in   = f_neg;
      end
      zero_in = (range_in == '0);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SETUP) begin
         dev_ff   <= dev_in;
         range_ff <= range_in;
         fac_ff   <= fac_in;
         neg_ff   <= neg_in;
         zero_ff  <= zero_in;
      end
   end

   // clamp and dead zone
   always_comb begin
      if (zero_ff) begin
         mag = '0;
      end else if (quotient[QUO_W-1]) begin
         mag = neg_ff ? POS_NEG_MAG : POS_POS_MAX;
      end else begin
         mag = {1'b0, quotient[QUO_W-2:0]};
      end
      forced = (mag < POS_W'(cfg.dead_zone));
      if (forced) begin
         pos_in = '0;
      end else if (neg_ff) begin
         pos_in = -mag;
      end else begin
         pos_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         pos_ff <= pos_in;
         dz_ff  <= forced;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.position     = pos_ff;
   assign rsp_bus.in_dead_zone = dz_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_SETUP))
      else $error("accepted beat did not start setup");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.in_dead_zone) |-> (rsp_bus.position == '0))
      else $error("dead zone beat with nonzero position");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_bus.valid && !rsp_bus.ready) |=> (state_ff == ST_FIN))
      else $error("pending result overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(QUO_W - 1)))
      else $error("divider step count out of range");
`endif

endmodule
